// ===== hdl/ryuv_pkg.sv =====
// Shared widths, register map and conversion constants for the RGB to YUV 4:2:0 converter.
`timescale 1ns / 1ps
package ryuv_pkg;

  localparam int unsigned COMP_W             = 8;
  localparam int unsigned SUM_W              = 9;
  localparam int unsigned CFG_W              = 13;
  localparam int unsigned PADDR_W            = 3;
  localparam int unsigned PDATA_W            = 32;
  localparam int unsigned MAX_LINE_WIDTH_DEF = 4096;
  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = CFG_W'(640);

  // register indexes (word address)
  localparam logic [PADDR_W-3:0] REG_LINE_WIDTH = '0;

  // luma coefficients, 8 fractional bits
  localparam logic [7:0] Y_R = 8'd77;
  localparam logic [7:0] Y_G = 8'd150;
  localparam logic [7:0] Y_B = 8'd29;

  // chroma coefficients applied to 2x2 sums
  localparam logic [7:0] CB_R = 8'd43;
  localparam logic [7:0] CB_G = 8'd85;
  localparam logic [7:0] CR_G = 8'd107;
  localparam logic [7:0] CR_B = 8'd21;

  typedef struct packed {
    logic [SUM_W-1:0] b;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] r;
  } pair_sum_t;

endpackage

// ===== hdl/ryuv_pix_if.sv =====
// Input pixel channel: valid/ready handshake with one RGB pixel as payload.
`timescale 1ns / 1ps
interface ryuv_pix_if;
  import ryuv_pkg::*;

  logic              valid;
  logic              ready;
  logic              start_of_frame;
  logic [COMP_W-1:0] red;
  logic [COMP_W-1:0] green;
  logic [COMP_W-1:0] blue;

  modport source (output valid, start_of_frame, red, green, blue, input ready);
  modport sink   (input valid, start_of_frame, red, green, blue, output ready);
endinterface

// ===== hdl/ryuv_yuv_if.sv =====
// Result channel: valid/ready handshake carrying luma and optional chroma.
`timescale 1ns / 1ps
interface ryuv_yuv_if;
  import ryuv_pkg::*;

  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] luma;
  logic              chroma_valid;
  logic [COMP_W-1:0] chroma_blue;
  logic [COMP_W-1:0] chroma_red;

  modport source (output valid, luma, chroma_valid, chroma_blue, chroma_red, input ready);
  modport sink   (input valid, luma, chroma_valid, chroma_blue, chroma_red, output ready);
endinterface

// ===== hdl/rgb_to_yuv420_top.sv =====
// Streaming RGB to YUV 4:2:0 converter (BT.601, 8-bit fixed point).
//
// Pixels enter on pix_i in raster order, one per handshake; start_of_frame
// puts row and column back to zero before that pixel is taken. Every pixel
// gives one item on yuv_o with its luma. On the odd-row, odd-column pixel
// that closes a 2x2 block the item also carries Cb and Cr with chroma_valid
// set; otherwise both chroma fields read zero.
// Even-row pair sums are parked in a line store of MAX_LINE_WIDTH/2 entries
// (one synchronous RAM, registered read) and read back by the odd row.
// A result passes through the stage-1 registers and then the output register.
// Throughput: one pixel per cycle while yuv_o is not stalled, set by the
// single RAM port pair: at most one pair-sum write and one read per pixel.
// A stalled receiver holds the output register; the middle stage still
// fills, after which pix_i.ready drops until the output is taken.
// Reset clears position, row parity, line width (640) and all valid flags;
// the line store is not cleared and holds whatever the even row wrote.
// Configuration: APB register line_width at address 0, which the user must write
// only while the block is idle; the block itself does not enforce this. Its low bit is ignored.
`timescale 1ns / 1ps
module rgb_to_yuv420_top #(
  parameter int unsigned MAX_LINE_WIDTH = ryuv_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ryuv_pkg::PADDR_W-1:0]  paddr,
  input  logic [ryuv_pkg::PDATA_W-1:0]  pwdata,
  output logic [ryuv_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  ryuv_pix_if.sink                      pix_i,
  ryuv_yuv_if.source                    yuv_o
);
  import ryuv_pkg::*;

  localparam int unsigned DEPTH = MAX_LINE_WIDTH / 2;
  localparam int unsigned CW    = (MAX_LINE_WIDTH > 2) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned EW    = 15;

  // configuration
  logic [CFG_W-1:0] line_width_q;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_LINE_WIDTH);
  assign prdata  = reg_hit ? PDATA_W'(line_width_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      line_width_q <= pwdata[CFG_W-1:0];
    end
  end

  logic [EW-1:0] width_even;
  logic [EW-1:0] width_eff;

  always_comb begin
    width_even = EW'({line_width_q[CFG_W-1:1], 1'b0});
    width_eff  = width_even;
    if (width_even < EW'(2)) begin
      width_eff = EW'(2);
    end
    if (width_even > EW'(MAX_LINE_WIDTH)) begin
      width_eff = EW'(MAX_LINE_WIDTH);
    end
  end

  // pipeline control
  logic s1_v_q, out_v_q;
  logic en1, en2, acc;

  assign en2         = !out_v_q || yuv_o.ready;
  assign en1         = !s1_v_q || en2;
  assign pix_i.ready = en1;
  assign acc         = pix_i.valid && en1;

  // position and pair sums
  logic [CW-1:0]    col_q, col_eff;
  logic             odd_q, odd_eff;
  pair_sum_t        pair_q, pair_new;
  logic [EW-1:0]    col_inc;
  logic [CW-1:0]    half_col;
  logic [AW-1:0]    idx;

  always_comb begin
    col_eff    = pix_i.start_of_frame ? '0 : col_q;
    odd_eff    = pix_i.start_of_frame ? 1'b0 : odd_q;
    pair_new.r = SUM_W'(pair_q.r) + SUM_W'(pix_i.red);
    pair_new.g = SUM_W'(pair_q.g) + SUM_W'(pix_i.green);
    pair_new.b = SUM_W'(pair_q.b) + SUM_W'(pix_i.blue);
    col_inc    = EW'(col_eff) + EW'(1);
    half_col   = col_eff >> 1;
    // wrap when the store depth is not a power of two
    idx        = (half_col >= CW'(DEPTH)) ? '0 : AW'(half_col);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      odd_q  <= 1'b0;
      pair_q <= '0;
    end else if (acc) begin
      if (col_inc >= width_eff) begin
        col_q <= '0;
        odd_q <= !odd_eff;
      end else begin
        col_q <= CW'(col_inc);
        odd_q <= odd_eff;
      end
      if (!col_eff[0]) begin
        pair_q <= '{b: SUM_W'(pix_i.blue), g: SUM_W'(pix_i.green), r: SUM_W'(pix_i.red)};
      end
    end
  end

  // line store: even row writes pair sums, odd row reads them a line later
  pair_sum_t mem [DEPTH];
  pair_sum_t rd_q;

  always_ff @(posedge clk_i) begin
    if (acc && !odd_eff && col_eff[0]) begin
      mem[idx] <= pair_new;
    end
    if (en1) begin
      rd_q <= mem[idx];
    end
  end

  // stage 1
  logic [COMP_W-1:0] s1_r_q, s1_g_q, s1_b_q;
  pair_sum_t         s1_sum_q;
  logic              s1_chr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en1) begin
      s1_v_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_r_q   <= pix_i.red;
      s1_g_q   <= pix_i.green;
      s1_b_q   <= pix_i.blue;
      s1_sum_q <= pair_new;
      s1_chr_q <= odd_eff && col_eff[0];
    end
  end

  // stage 2: luma and chroma
  logic [15:0] y_acc;
  logic [9:0]  rs, gs, bs;
  logic [18:0] cb_acc, cr_acc;

  always_comb begin
    y_acc  = 16'(s1_r_q * Y_R) + 16'(s1_g_q * Y_G) + 16'(s1_b_q * Y_B) + 16'd128;
    rs     = 10'(s1_sum_q.r) + 10'(rd_q.r);
    gs     = 10'(s1_sum_q.g) + 10'(rd_q.g);
    bs     = 10'(s1_sum_q.b) + 10'(rd_q.b);
    // offset (128 << 10) + 511 keeps both sums non-negative over the full block range
    cb_acc = (19'(bs) << 7) + 19'd131583 - 19'(rs * CB_R) - 19'(gs * CB_G);
    cr_acc = (19'(rs) << 7) + 19'd131583 - 19'(gs * CR_G) - 19'(bs * CR_B);
  end

  logic [COMP_W-1:0] luma_q, cb_q, cr_q;
  logic              cv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en2) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      luma_q <= y_acc[15:8];
      cv_q   <= s1_chr_q;
      cb_q   <= s1_chr_q ? cb_acc[17:10] : '0;
      cr_q   <= s1_chr_q ? cr_acc[17:10] : '0;
    end
  end

  assign yuv_o.valid        = out_v_q;
  assign yuv_o.luma         = luma_q;
  assign yuv_o.chroma_valid = cv_q;
  assign yuv_o.chroma_blue  = cb_q;
  assign yuv_o.chroma_red   = cr_q;

endmodule
